// ===== hw/rtl/b3c_pkg.sv =====
// ----------------------------------------------------------------------------
// b3c_pkg
// Constants, types and helpers for the modified compression block: IV words,
// the seven-row message schedule, word rotations and state row rotation.
// ----------------------------------------------------------------------------
`default_nettype none

package b3c_pkg;

  // default number of rounds
  localparam int B3C_ROUNDS = 7;

  // one state row of four 32-bit words, element i is word i of the row
  typedef logic [3:0][31:0] b3c_row_t;

  // sequencer codes
  localparam logic [1:0] B3C_IDLE = 2'd0;
  localparam logic [1:0] B3C_RUN  = 2'd1;
  localparam logic [1:0] B3C_DONE = 2'd2;

  // initial words of the upper half of the state
  localparam logic [31:0] B3C_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9EB, 32'h5BE0CD19
  };

  // message schedule, one row per round
  localparam logic [3:0] B3C_SCHED [7][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd12, 4'd8, 4'd13, 4'd9, 4'd14, 4'd10, 4'd15, 4'd11,
      4'd6, 4'd2, 4'd7, 4'd3, 4'd0, 4'd4, 4'd1, 4'd5},
    '{4'd11, 4'd15, 4'd10, 4'd14, 4'd3, 4'd7, 4'd2, 4'd6,
      4'd1, 4'd5, 4'd0, 4'd4, 4'd13, 4'd9, 4'd12, 4'd8},
    '{4'd1, 4'd12, 4'd7, 4'd10, 4'd14, 4'd0, 4'd5, 4'd15,
      4'd13, 4'd3, 4'd9, 4'd2, 4'd6, 4'd11, 4'd4, 4'd8},
    '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd1,
      4'd7, 4'd10, 4'd3, 4'd4, 4'd11, 4'd0, 4'd6, 4'd13},
    '{4'd10, 4'd2, 4'd8, 4'd12, 4'd15, 4'd11, 4'd14, 4'd6,
      4'd4, 4'd0, 4'd13, 4'd7, 4'd5, 4'd1, 4'd9, 4'd3},
    '{4'd13, 4'd7, 4'd9, 4'd1, 4'd11, 4'd14, 4'd12, 4'd3,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10}
  };

  // message word index for a round and a half-mix position
  function automatic logic [3:0] sched_word(input logic [2:0] rnd, input logic [3:0] pos);
    logic [3:0] w;
    case (rnd)
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6: w = B3C_SCHED[rnd][pos];
      default: w = B3C_SCHED[0][pos];
    endcase
    return w;
  endfunction

  // rotate a word left
  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    return (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

  // rotate a row left by whole words: word 0 takes old word amt
  function automatic b3c_row_t rot_row(input b3c_row_t row, input logic [1:0] amt);
    b3c_row_t r;
    for (int i = 0; i < 4; i++) begin
      r[i] = row[2'(i + int'(amt))];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/custom_blake3_compress.sv =====
// ----------------------------------------------------------------------------
// custom_blake3_compress
// Modified compression block. Loads the chaining value and a 16-word message
// as 64-bit pairs; message pair 7 runs the rounds on one shared half-mix unit
// and emits the new chaining value.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  input   | in_mode, in_pair_index, in_data_pair,   | start high, busy low
//          | in_block_counter, in_block_length,      |
//          | in_domain_flags                         |
//  result  | out_cv_words_01/23/45/67                | out_valid, one cycle
//
//  Busy stays low through the loads.
//  Message pair 7 holds busy while the rounds run: one half-mix per cycle
//  on the single shared mix unit, 16 per round, then the final xor.
//  The result strobe comes on the cycle busy drops; a new item can be taken then.
//  The receiver cannot stall. Reset clears the chaining value and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module custom_blake3_compress #(
  parameter int ROUNDS = b3c_pkg::B3C_ROUNDS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_mode,
  input  wire logic [2:0]  in_pair_index,
  input  wire logic [63:0] in_data_pair,
  input  wire logic [63:0] in_block_counter,
  input  wire logic [6:0]  in_block_length,
  input  wire logic [7:0]  in_domain_flags,
  output logic             out_valid,
  output logic [63:0]      out_cv_words_01,
  output logic [63:0]      out_cv_words_23,
  output logic [63:0]      out_cv_words_45,
  output logic [63:0]      out_cv_words_67
);
  import b3c_pkg::*;

  localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [RW-1:0] LAST_RND = RW'(ROUNDS - 1);

  logic [1:0]    fsm_r;
  logic [1:0]    fsm_nxt;
  logic [3:0]    step_r;
  logic [RW-1:0] rnd_r;
  logic [31:0]   cv_r [8];
  logic [31:0]   msg_r [16];
  b3c_row_t      st_r [4];
  b3c_row_t      st_nxt [4];
  logic          out_valid_r;
  logic [63:0]   out01_r, out23_r, out45_r, out67_r;

  logic          accept;
  logic          fire;
  logic          half;
  logic [31:0]   mw;
  logic [31:0]   a1, b1, c1, d1;
  logic [31:0]   a0, b0, c0, d0;

  assign busy   = (fsm_r != B3C_IDLE);
  assign accept = start && !busy;
  assign fire   = accept && in_mode && (in_pair_index == 3'd7);
  assign half   = step_r[0];

  // shared half-mix on column 0 of the state
  always_comb begin
    a0 = st_r[0][0];
    b0 = st_r[1][0];
    c0 = st_r[2][0];
    d0 = st_r[3][0];
    mw = msg_r[sched_word(3'(rnd_r), step_r)];
    a1 = a0 + b0 + mw;
    d1 = rol32(d0 ^ a1, half ? 5'd8 : 5'd16);
    c1 = c0 + d1;
    b1 = rol32(b0 ^ c1, half ? 5'd7 : 5'd12);
  end

  // write back column 0, then rotate rows after a full mix
  always_comb begin
    b3c_row_t upd [4];
    upd = st_r;
    upd[0][0] = a1;
    upd[1][0] = b1;
    upd[2][0] = c1;
    upd[3][0] = d1;
    for (int r = 0; r < 4; r++) begin
      if (!half) begin
        st_nxt[r] = upd[r];
      end else if (step_r[3:1] == 3'd3) begin
        // last column mix: step to the diagonal layout
        st_nxt[r] = rot_row(upd[r], 2'(1 + r));
      end else if (step_r[3:1] == 3'd7) begin
        // last diagonal mix: back to the column layout
        st_nxt[r] = rot_row(upd[r], 2'(1 - r));
      end else begin
        st_nxt[r] = rot_row(upd[r], 2'd1);
      end
    end
  end

  // sequencer next state
  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      B3C_IDLE: if (fire) fsm_nxt = B3C_RUN;
      B3C_RUN:  if (step_r == 4'd15 && rnd_r == LAST_RND) fsm_nxt = B3C_DONE;
      B3C_DONE: fsm_nxt = B3C_IDLE;
      default:  fsm_nxt = B3C_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= B3C_IDLE;
      step_r      <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      out_valid_r <= (fsm_r == B3C_DONE);
      if (fsm_r == B3C_RUN) begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'd15) begin
          rnd_r <= (rnd_r == LAST_RND) ? '0 : rnd_r + RW'(1);
        end
      end else begin
        step_r <= '0;
        rnd_r  <= '0;
      end
    end
  end

  // chaining value: loads and the final xor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= '0;
      end
    end else if (fsm_r == B3C_DONE) begin
      for (int i = 0; i < 4; i++) begin
        cv_r[i]     <= st_r[0][i] ^ st_r[2][i];
        cv_r[i + 4] <= st_r[1][i] ^ st_r[3][i];
      end
    end else if (accept && !in_mode && !in_pair_index[2]) begin
      cv_r[{in_pair_index[1:0], 1'b0}] <= in_data_pair[31:0];
      cv_r[{in_pair_index[1:0], 1'b1}] <= in_data_pair[63:32];
    end
  end

  // message words
  always_ff @(posedge clk) begin
    if (accept && in_mode) begin
      msg_r[{in_pair_index, 1'b0}] <= in_data_pair[31:0];
      msg_r[{in_pair_index, 1'b1}] <= in_data_pair[63:32];
    end
  end

  // working state: loaded on message pair 7, then one half-mix a cycle
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < 4; i++) begin
        st_r[0][i] <= cv_r[i];
        st_r[1][i] <= cv_r[i + 4];
        st_r[2][i] <= B3C_IV[i];
      end
      st_r[3][0] <= B3C_IV[4] ^ in_block_counter[31:0];
      st_r[3][1] <= B3C_IV[5] ^ in_block_counter[63:32];
      st_r[3][2] <= B3C_IV[6] ^ {25'd0, in_block_length};
      st_r[3][3] <= B3C_IV[7] ^ {24'd0, in_domain_flags};
    end else if (fsm_r == B3C_RUN) begin
      st_r <= st_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (fsm_r == B3C_DONE) begin
      out01_r <= {st_r[0][1] ^ st_r[2][1], st_r[0][0] ^ st_r[2][0]};
      out23_r <= {st_r[0][3] ^ st_r[2][3], st_r[0][2] ^ st_r[2][2]};
      out45_r <= {st_r[1][1] ^ st_r[3][1], st_r[1][0] ^ st_r[3][0]};
      out67_r <= {st_r[1][3] ^ st_r[3][3], st_r[1][2] ^ st_r[3][2]};
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cv_words_01 = out01_r;
  assign out_cv_words_23 = out23_r;
  assign out_cv_words_45 = out45_r;
  assign out_cv_words_67 = out67_r;

  // checks
  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> busy)
    else $error("compression did not start on message pair 7");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == B3C_RUN) |-> (rnd_r <= LAST_RND))
    else $error("round counter out of range");

  a_done_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == B3C_DONE) |-> ($past(fsm_r) == B3C_RUN && $past(step_r) == 4'd15))
    else $error("finish without a full last round");

endmodule

`default_nettype wire
